@@ sv/cdg_pkg.sv @@
// ----------------------------------------------------------------------------
// cdg_pkg: shared types and constants for the camera ray direction generator
// Holds the configuration bundle, sequencer states and the inverse square
// root seed table.
// ----------------------------------------------------------------------------
package cdg_pkg;

    localparam int VEC_BITS      = 21;
    localparam int INV_BITS      = 25;
    localparam int INV_FRAC      = 24;
    localparam int RNG_BITS      = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 63;

    localparam logic [34:0] LCG_MUL = 35'h5DEECE66D;
    localparam logic [47:0] LCG_ADD = 48'hB;

    localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_H   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED    = 3'd4;

    localparam logic [INV_BITS-1:0] INV_H_RESET = 25'd65536;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] forward;
        logic [CFG_DATA_BITS-1:0] right;
        logic [CFG_DATA_BITS-1:0] up;
        logic [INV_BITS-1:0]      inv_height;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LCG,
        F_JIT,
        F_FILMX,
        F_FILMY,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MULR,
        B_MULU,
        B_ACC,
        B_CHECK,
        B_NORM,
        B_SQ,
        B_MANT,
        B_NY2,
        B_NT,
        B_NY,
        B_SCALE,
        B_OUT
    } back_state_t;

    // Q0.16 seed for 1/sqrt, indexed by the top four mantissa bits;
    // indexes below four clamp to the first entry
    function automatic logic [15:0] seed_lookup(input logic [3:0] idx);
        logic [15:0] s;
        case (idx)
            4'd5:    s = 16'd55889;
            4'd6:    s = 16'd51410;
            4'd7:    s = 16'd47861;
            4'd8:    s = 16'd44957;
            4'd9:    s = 16'd42525;
            4'd10:   s = 16'd40450;
            4'd11:   s = 16'd38651;
            4'd12:   s = 16'd37073;
            4'd13:   s = 16'd35673;
            4'd14:   s = 16'd34421;
            4'd15:   s = 16'd33292;
            default: s = 16'd61788;
        endcase
        return s;
    endfunction

endpackage

@@ sv/cdg_front.sv @@
// ----------------------------------------------------------------------------
// cdg_front: request intake, jitter generator and film offsets
// Accepts a pixel request, steps the 48-bit generator when jitter is asked
// for and forms the two film offsets for the back end.
// ----------------------------------------------------------------------------
module cdg_front
    import cdg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 18,
    parameter int UW         = COORD_BITS + FRAC_BITS + 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic                  use_jitter,
    input  logic [INV_BITS-1:0]   inv_height,
    input  logic                  seed_load,
    input  logic [RNG_BITS-1:0]   seed_value,
    input  logic                  q_full,
    output logic                  q_push,
    output logic signed [UW-1:0]  q_ux,
    output logic signed [UW-1:0]  q_uy
);

    localparam int JW = INV_BITS + 1;
    localparam int QW = COORD_BITS + 28;

    front_state_t state_reg, state_next;

    logic [RNG_BITS-1:0]   rng_reg;
    logic [RNG_BITS-1:0]   acc_reg;
    logic [1:0]            k_reg;
    logic                  which_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [JW-1:0]  jx_reg, jy_reg;
    logic signed [UW-1:0]  ux_reg, uy_reg;

    logic [50:0]          lcg_prod;
    logic [RNG_BITS-1:0]  lcg_term;
    logic [RNG_BITS-1:0]  acc_sum;
    logic [48:0]          jit_prod;
    logic signed [JW-1:0] jit_val;
    logic [COORD_BITS:0]  odd_p;
    logic signed [JW-1:0] film_j;
    logic [COORD_BITS+INV_BITS:0] film_prod;
    logic signed [QW-1:0] film_q;

    // one 16-bit slice of the state per cycle against the multiplier
    assign lcg_prod = rng_reg[{k_reg, 4'd0} +: 16] * LCG_MUL;
    assign lcg_term = lcg_prod[RNG_BITS-1:0] << {k_reg, 4'd0};
    assign acc_sum  = acc_reg + lcg_term;

    assign jit_prod = rng_reg[47:24] * inv_height;
    assign jit_val  = $signed({1'b0, jit_prod[48:24]}) - $signed({2'b00, inv_height[24:1]});

    assign odd_p     = (state_reg == F_FILMX) ? {px_reg, 1'b1} : {py_reg, 1'b1};
    assign film_j    = (state_reg == F_FILMX) ? jx_reg : jy_reg;
    assign film_prod = odd_p * inv_height;
    assign film_q    = $signed({2'b00, film_prod}) - $signed(QW'(1) <<< INV_FRAC)
                     + QW'(film_j);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
                if (in_valid)
                begin
                    state_next = use_jitter ? F_LCG : F_FILMX;
                end
            F_LCG:
                if (k_reg == 2'd2)
                begin
                    state_next = F_JIT;
                end
            F_JIT:   state_next = which_reg ? F_FILMX : F_LCG;
            F_FILMX: state_next = F_FILMY;
            F_FILMY: state_next = F_PUSH;
            F_PUSH:
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != F_IDLE);
        q_push   = (state_reg == F_PUSH) && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rng_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_load)
            begin
                rng_reg <= seed_value;
            end
            else if (state_reg == F_LCG && k_reg == 2'd2)
            begin
                rng_reg <= acc_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                px_reg    <= pixel_x;
                py_reg    <= pixel_y;
                jx_reg    <= '0;
                jy_reg    <= '0;
                which_reg <= 1'b0;
                k_reg     <= 2'd0;
                acc_reg   <= LCG_ADD;
            end
            F_LCG:
            begin
                acc_reg <= acc_sum;
                k_reg   <= k_reg + 2'd1;
            end
            F_JIT:
            begin
                if (which_reg)
                begin
                    jy_reg <= jit_val;
                end
                else
                begin
                    jx_reg <= jit_val;
                end
                which_reg <= 1'b1;
                k_reg     <= 2'd0;
                acc_reg   <= LCG_ADD;
            end
            F_FILMX: ux_reg <= film_q[QW-1:INV_FRAC-FRAC_BITS];
            F_FILMY: uy_reg <= film_q[QW-1:INV_FRAC-FRAC_BITS];
            default: ;
        endcase
    end

    assign q_ux = ux_reg;
    assign q_uy = uy_reg;

endmodule

@@ sv/cdg_queue.sv @@
// ----------------------------------------------------------------------------
// cdg_queue: two-entry queue between front and back end
// Holds film offset pairs so each side can stall on its own.
// ----------------------------------------------------------------------------
module cdg_queue
    import cdg_pkg::*;
#(
    parameter int WIDTH = 68
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign data_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

@@ sv/cdg_back.sv @@
// ----------------------------------------------------------------------------
// cdg_back: direction build, block scaling and normalisation
// Forms the unnormalised direction, scales it, runs the Newton reciprocal
// square root and writes the rounded unit vector, or zeros when degenerate,
// to the output register.
module cdg_back
    import cdg_pkg::*;
#(
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 18,
    parameter int NEWTON_STEPS = 3,
    parameter int UW           = COORD_BITS + FRAC_BITS + 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       q_empty,
    input  logic signed [UW-1:0]       q_ux,
    input  logic signed [UW-1:0]       q_uy,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [FRAC_BITS+1:0] dir_x,
    output logic signed [FRAC_BITS+1:0] dir_y,
    output logic signed [FRAC_BITS+1:0] dir_z,
    output logic                       degenerate
);

    localparam int OW     = FRAC_BITS + 2;
    localparam int PW     = UW + VEC_BITS;
    localparam int VW     = UW + 23;
    localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
    localparam int SH22   = 52 - FRAC_BITS;
    localparam int SH23   = 53 - FRAC_BITS;

    back_state_t state_reg, state_next;

    logic signed [UW-1:0] ux_reg, uy_reg;
    logic [1:0]           comp_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic [VW-1:0]        a_reg [3];
    logic [2:0]           neg_reg;
    logic [VW-1:0]        mx_reg;
    logic [47:0]          s_reg;
    logic [31:0]          m_reg;
    logic                 base23_reg;
    logic [30:0]          y_reg;
    logic [31:0]          y2_reg;
    logic [31:0]          f_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [OW-1:0]        dir_reg [3];
    logic                 deg_reg;
    logic                 out_valid_reg;
    logic [OW-1:0]        ox_reg, oy_reg, oz_reg;
    logic                 odeg_reg;

    logic signed [VEC_BITS-1:0] f_c, r_c, u_c;
    logic signed [VW-1:0]       v_sum;
    logic [VW-1:0]              v_abs;
    logic [22:0]                c_cur;
    logic [45:0]                c_sq;
    logic [61:0]                yy;
    logic [63:0]                mt;
    logic [33:0]                t_val;
    logic [62:0]                yf;
    logic [31:0]                y_new;
    logic [53:0]                cy;
    logic [54:0]                cy_rnd;
    logic [22:0]                mag;
    logic [OW-1:0]              mag_sat;
    logic                       out_load;

    always_comb
    begin
        case (comp_reg)
            2'd1:
            begin
                f_c = cfg.forward[41:21];
                r_c = cfg.right[41:21];
                u_c = cfg.up[41:21];
            end
            2'd2:
            begin
                f_c = cfg.forward[62:42];
                r_c = cfg.right[62:42];
                u_c = cfg.up[62:42];
            end
            default:
            begin
                f_c = cfg.forward[20:0];
                r_c = cfg.right[20:0];
                u_c = cfg.up[20:0];
            end
        endcase
    end

    assign v_sum = (VW'(f_c) <<< (FRAC_BITS + 1)) + VW'(p1_reg) + VW'(p2_reg);
    assign v_abs = v_sum[VW-1] ? VW'(-v_sum) : VW'(v_sum);

    assign c_cur = a_reg[comp_reg][22:0];
    assign c_sq  = c_cur * c_cur;

    assign yy    = y_reg * y_reg;
    assign mt    = m_reg * y2_reg;
    assign t_val = mt[63:30];
    assign yf    = y_reg * f_reg;
    assign y_new = yf[62:31];

    // rounded half up, then clamped to one
    assign cy     = c_cur * y_reg;
    assign cy_rnd = base23_reg ? ((55'(cy) + (55'(1) << (SH23 - 1))) >> SH23)
                               : ((55'(cy) + (55'(1) << (SH22 - 1))) >> SH22);
    assign mag    = cy_rnd[22:0];
    assign mag_sat = (mag > (23'(1) << FRAC_BITS)) ? (OW'(1) << FRAC_BITS) : OW'(mag);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    state_next = B_MULR;
                end
            B_MULR:  state_next = B_MULU;
            B_MULU:  state_next = B_ACC;
            B_ACC:   state_next = (comp_reg == 2'd2) ? B_CHECK : B_MULR;
            B_CHECK: state_next = (mx_reg == '0) ? B_OUT : B_NORM;
            B_NORM:
                if (mx_reg < (VW'(1) << 23) && mx_reg >= (VW'(1) << 22))
                begin
                    state_next = B_SQ;
                end
            B_SQ:    state_next = (comp_reg == 2'd2) ? B_MANT : B_SQ;
            B_MANT:  state_next = B_NY2;
            B_NY2:   state_next = B_NT;
            B_NT:    state_next = B_NY;
            B_NY:    state_next = (step_reg == STEP_W'(NEWTON_STEPS - 1)) ? B_SCALE : B_NY2;
            B_SCALE: state_next = (comp_reg == 2'd2) ? B_OUT : B_SCALE;
            B_OUT:
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = B_IDLE;
                end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        out_load = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                ux_reg   <= q_ux;
                uy_reg   <= q_uy;
                comp_reg <= 2'd0;
                mx_reg   <= '0;
            end
            B_MULR: p1_reg <= ux_reg * r_c;
            B_MULU: p2_reg <= uy_reg * u_c;
            B_ACC:
            begin
                a_reg[comp_reg]   <= v_abs;
                neg_reg[comp_reg] <= v_sum[VW-1];
                if (v_abs > mx_reg)
                begin
                    mx_reg <= v_abs;
                end
                comp_reg <= comp_reg + 2'd1;
            end
            B_CHECK:
            begin
                deg_reg    <= (mx_reg == '0);
                dir_reg[0] <= '0;
                dir_reg[1] <= '0;
                dir_reg[2] <= '0;
            end
            B_NORM:
            begin
                // coarse then fine steps until the peak sits in [2^22, 2^23)
                if (mx_reg >= (VW'(1) << 30))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] >> 8;
                    end
                    mx_reg <= mx_reg >> 8;
                end
                else if (mx_reg >= (VW'(1) << 23))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] >> 1;
                    end
                    mx_reg <= mx_reg >> 1;
                end
                else if (mx_reg < (VW'(1) << 14))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] << 8;
                    end
                    mx_reg <= mx_reg << 8;
                end
                else if (mx_reg < (VW'(1) << 22))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] << 1;
                    end
                    mx_reg <= mx_reg << 1;
                end
                comp_reg <= 2'd0;
                s_reg    <= '0;
            end
            B_SQ:
            begin
                s_reg    <= s_reg + 48'(c_sq);
                comp_reg <= comp_reg + 2'd1;
            end
            B_MANT:
            begin
                if (s_reg[47:46] != 2'b00)
                begin
                    m_reg      <= s_reg[47:16];
                    base23_reg <= 1'b1;
                    y_reg      <= {1'b0, seed_lookup(s_reg[47:44]), 14'd0};
                end
                else
                begin
                    m_reg      <= s_reg[45:14];
                    base23_reg <= 1'b0;
                    y_reg      <= {1'b0, seed_lookup(s_reg[45:42]), 14'd0};
                end
                step_reg <= '0;
            end
            B_NY2: y2_reg <= yy[61:30];
            B_NT:  f_reg <= (t_val < 34'h0C0000000) ? 32'(34'h0C0000000 - t_val) : 32'd0;
            B_NY:
            begin
                y_reg    <= y_new[31] ? 31'h7FFFFFFF : y_new[30:0];
                step_reg <= step_reg + STEP_W'(1);
                comp_reg <= 2'd0;
            end
            B_SCALE:
            begin
                dir_reg[comp_reg] <= neg_reg[comp_reg] ? (OW'(0) - mag_sat) : mag_sat;
                comp_reg          <= comp_reg + 2'd1;
            end
            default: ;
        endcase

        if (out_load)
        begin
            ox_reg   <= dir_reg[0];
            oy_reg   <= dir_reg[1];
            oz_reg   <= dir_reg[2];
            odeg_reg <= deg_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dir_x      = ox_reg;
    assign dir_y      = oy_reg;
    assign dir_z      = oz_reg;
    assign degenerate = odeg_reg;

endmodule

@@ sv/camera_ray_direction_generator.sv @@
// ----------------------------------------------------------------------------
// camera_ray_direction_generator: pinhole camera primary ray directions
// Turns a pixel request into the unit direction of its primary ray.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries pixel_x, pixel_y, use_jitter.
//   A request is taken when in_valid is high and in_stall is low.
//   Output channel (out_valid/out_stall) carries dir_x/y/z (signed Q1.18)
//   and degenerate; the result is held until out_stall is low.
//   Configure the basis vectors, inv_height and rng_seed through
//   cfg_write/cfg_index/cfg_data while idle; writing rng_seed also reloads
//   the jitter generator.
// Sequencing:
//   Front end: forms both film offsets per request; with jitter it first
//   runs two generator steps, each of three 16x35 partial products plus a
//   jitter step, on one serial generator multiplier.
//   Back end: builds, block-scales and normalises one direction at a time
//   through its serial Newton loop and takes the next queue entry only
//   after it has written the result. A two-entry queue lets the front take the next request meanwhile.
// Reset clears all control state, loads inv_height with 1/256, zeroes the
//   other configuration registers and the generator. A stalled receiver
//   backs up the back end, then the queue, then the input channel.
// ----------------------------------------------------------------------------
module camera_ray_direction_generator
    import cdg_pkg::*;
#(
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 18,
    parameter int NEWTON_STEPS = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [COORD_BITS-1:0]        pixel_x,
    input  logic [COORD_BITS-1:0]        pixel_y,
    input  logic                         use_jitter,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [FRAC_BITS+1:0]  dir_x,
    output logic signed [FRAC_BITS+1:0]  dir_y,
    output logic signed [FRAC_BITS+1:0]  dir_z,
    output logic                         degenerate
);

    localparam int UW = COORD_BITS + FRAC_BITS + 4;

    cfg_t cfg_reg;
    logic seed_load;

    logic                 q_push, q_full, q_pop, q_empty;
    logic signed [UW-1:0] f_ux, f_uy;
    logic [2*UW-1:0]      q_rd;

    // configuration registers; the seed goes straight into the generator
    assign seed_load = cfg_write && (cfg_index == REG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward    <= '0;
            cfg_reg.right      <= '0;
            cfg_reg.up         <= '0;
            cfg_reg.inv_height <= INV_H_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FORWARD: cfg_reg.forward    <= cfg_data;
                REG_RIGHT:   cfg_reg.right      <= cfg_data;
                REG_UP:      cfg_reg.up         <= cfg_data;
                REG_INV_H:   cfg_reg.inv_height <= cfg_data[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    cdg_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .UW         (UW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .use_jitter (use_jitter),
        .inv_height (cfg_reg.inv_height),
        .seed_load  (seed_load),
        .seed_value (cfg_data[RNG_BITS-1:0]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ux       (f_ux),
        .q_uy       (f_uy)
    );

    cdg_queue #(
        .WIDTH (2 * UW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  ({f_ux, f_uy}),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_rd),
        .empty    (q_empty)
    );

    cdg_back #(
        .COORD_BITS   (COORD_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .NEWTON_STEPS (NEWTON_STEPS),
        .UW           (UW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_ux       (q_rd[2*UW-1:UW]),
        .q_uy       (q_rd[UW-1:0]),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .degenerate (degenerate)
    );

endmodule
